// File: sv/url_percent_decoder_top_defines.svh
// Assertion macros used by the URL percent decoder checker.
`ifndef URL_PERCENT_DECODER_TOP_DEFINES_SVH
`define URL_PERCENT_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define UPD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define UPD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/upd_pkg.sv
// Types, codes and helpers for the URL percent decoder.
package upd_pkg;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_PCT  = 2'd1,
		PH_HEX1 = 2'd2
	} esc_phase_t;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_MALFORMED = 2'd1;
	localparam logic [1:0] ST_TOO_LONG  = 2'd2;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_digit_t;

	function automatic hex_digit_t hex_decode(input logic [7:0] ch);
		hex_digit_t r;
		r.ok  = 1'b1;
		r.val = 4'd0;
		if (ch >= 8'h30 && ch <= 8'h39) begin
			r.val = ch[3:0];
		end else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
			// letters a-f and A-F share the low bits 1..6
			r.val = 4'd9 + ch[3:0];
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage

// File: sv/url_percent_decoder_top.sv
// URL percent decoder: one input byte per cycle while s_axis_tready is high, registered result.
//
// Usage:
//   s_axis carries the encoded string, one character per transfer in tdata,
//   tlast on the final character. m_axis carries results: tdata is the
//   decoded byte, tuser[0] flags it as present, tuser[2:1] is the string
//   status (ok, malformed escape, too long) and tlast closes the string.
//   A character that completes no token and is not last gives no transfer;
//   the last character always gives one, carrying the status.
//   cfg_valid/cfg_data set the most decoded bytes allowed per string;
//   cfg_ready is always high. Write it only between strings.
// Timing: a result appears on m_axis in the cycle after its character is taken.
// Throughput: one character per cycle while s_axis_tready is high; the decode is one
//   pass of byte compares and a nibble merge into the result register.
// Reset: clears the escape state, byte count and status, empties the result
//   register and loads the length limit with 4095.
// Stall: the result register holds while m_axis_tready is low; s_axis_tready
//   drops only while that register is full and not being taken.
module url_percent_decoder_top
	import upd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
	output logic [2:0]  m_axis_tuser,   // [0] out_valid, [2:1] status
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	esc_phase_t phase_q, phase_nxt;
	logic [3:0]  nib_q, nib_nxt;
	logic [15:0] count_q, count_nxt;
	logic [1:0]  stat_q, stat_nxt;
	logic [15:0] max_len_q;

	logic        ovalid_q;
	logic [7:0]  obyte_q;
	logic        ohave_q;
	logic        olast_q;
	logic [1:0]  ostat_q;

	logic        accept;
	logic        have;
	logic [7:0]  dec_byte;
	logic        emit;
	hex_digit_t  hd;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !ovalid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign hd            = hex_decode(s_axis_tdata);

	// next escape state and status
	always_comb begin
		phase_nxt = phase_q;
		nib_nxt   = nib_q;
		stat_nxt  = stat_q;
		if (stat_q == ST_OK) begin
			unique case (phase_q)
				PH_IDLE: begin
					if (count_q >= max_len_q) begin
						stat_nxt = ST_TOO_LONG;
					end else if (s_axis_tdata == CH_PERCENT) begin
						phase_nxt = PH_PCT;
					end
				end
				PH_PCT: begin
					if (s_axis_tdata == CH_PERCENT) begin
						phase_nxt = PH_IDLE;
					end else if (hd.ok) begin
						nib_nxt   = hd.val;
						phase_nxt = PH_HEX1;
					end else begin
						stat_nxt  = ST_MALFORMED;
						phase_nxt = PH_IDLE;
					end
				end
				PH_HEX1: begin
					if (!hd.ok) begin
						stat_nxt = ST_MALFORMED;
					end
					phase_nxt = PH_IDLE;
				end
				default: phase_nxt = PH_IDLE;
			endcase
		end
		// escape still open at end of string
		if (s_axis_tlast && stat_nxt == ST_OK && phase_nxt != PH_IDLE) begin
			stat_nxt = ST_MALFORMED;
		end
	end

	// decoded byte
	always_comb begin
		have     = 1'b0;
		dec_byte = 8'd0;
		if (stat_q == ST_OK) begin
			unique case (phase_q)
				PH_IDLE: begin
					if (count_q < max_len_q && s_axis_tdata != CH_PERCENT) begin
						have     = 1'b1;
						dec_byte = (s_axis_tdata == CH_PLUS) ? CH_SPACE : s_axis_tdata;
					end
				end
				PH_PCT: begin
					if (s_axis_tdata == CH_PERCENT) begin
						have     = 1'b1;
						dec_byte = CH_PERCENT;
					end
				end
				PH_HEX1: begin
					if (hd.ok) begin
						have     = 1'b1;
						dec_byte = {nib_q, hd.val};
					end
				end
				default: have = 1'b0;
			endcase
		end
		count_nxt = count_q + {15'd0, have};
		emit      = have || s_axis_tlast;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			nib_q     <= 4'd0;
			count_q   <= 16'd0;
			stat_q    <= ST_OK;
			max_len_q <= 16'd4095;
		end else begin
			if (cfg_valid) begin
				max_len_q <= cfg_data;
			end
			if (accept) begin
				if (s_axis_tlast) begin
					// close the string: clear per-string state
					phase_q <= PH_IDLE;
					nib_q   <= 4'd0;
					count_q <= 16'd0;
					stat_q  <= ST_OK;
				end else begin
					phase_q <= phase_nxt;
					nib_q   <= nib_nxt;
					count_q <= count_nxt;
					stat_q  <= stat_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (accept && emit) begin
			ovalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			obyte_q <= dec_byte;
			ohave_q <= have;
			olast_q <= s_axis_tlast;
			ostat_q <= s_axis_tlast ? stat_nxt : ST_OK;
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = obyte_q;
	assign m_axis_tuser  = {ostat_q, ohave_q};
	assign m_axis_tlast  = olast_q;

endmodule

// File: sv/upd_checker.sv
// Port-level checks for the URL percent decoder, bound to its top level.
`include "url_percent_decoder_top_defines.svh"

module upd_checker
	import upd_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata,   // [7:0] out_byte
	input logic [2:0]  m_axis_tuser,   // [0] out_valid, [2:1] status
	input logic        m_axis_tlast
);

	// a stalled result holds
	`UPD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast),
		"result changed while stalled")

	// an empty result only closes a string and carries a zero byte
	`UPD_ASSERT_NOW(a_empty_is_last, m_axis_tvalid && !m_axis_tuser[0],
		m_axis_tlast && m_axis_tdata == 8'd0, "empty result without tlast")

	// status only on the closing result, and only a defined code
	`UPD_ASSERT_NOW(a_status_code, m_axis_tvalid,
		(m_axis_tlast || m_axis_tuser[2:1] == ST_OK) && m_axis_tuser[2:1] != 2'd3,
		"bad status on result")

	// input side is open whenever the result register is empty
	`UPD_ASSERT_NOW(a_ready_when_empty, !m_axis_tvalid, s_axis_tready,
		"input stalled with empty result register")

endmodule

bind url_percent_decoder_top upd_checker u_upd_checker (.*);

// File: tb/tb_url_percent_decoder_top.sv
// Self-checking testbench for the URL percent decoder stream block.
`timescale 1ns / 1ps

module tb_url_percent_decoder_top;
	import upd_pkg::*;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_F  = 8'h46;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_LOW_F = 8'h66;
	localparam int ITEMS_PER_PHASE = 133;
	localparam int NUM_PHASES      = 7;

	// Tracks the decoder state and holds the decoded results still owed.
	class decode_scoreboard;
		typedef struct {
			logic [7:0] data;
			logic       present;
			logic       closing;
			logic [1:0] status;
		} decoded_t;

		decoded_t   owed_q[$];
		logic [15:0] max_len;
		esc_phase_t phase;
		logic [3:0] high_nib;
		logic [15:0] out_count;
		logic [1:0] sticky;
		int         mismatches;

		function new();
			max_len    = 16'd4095;
			mismatches = 0;
			clear_string();
		endfunction

		function void clear_string();
			phase     = PH_IDLE;
			high_nib  = 4'd0;
			out_count = 16'd0;
			sticky    = ST_OK;
		endfunction

		function bit digit_value(input logic [7:0] ch, output logic [3:0] v);
			v = 4'd0;
			if (ch >= CH_ZERO && ch <= CH_NINE) begin
				v = 4'(ch - CH_ZERO);
				return 1'b1;
			end
			if (ch >= CH_LOW_A && ch <= CH_LOW_F) begin
				v = 4'(ch - CH_LOW_A + 8'd10);
				return 1'b1;
			end
			if (ch >= CH_UP_A && ch <= CH_UP_F) begin
				v = 4'(ch - CH_UP_A + 8'd10);
				return 1'b1;
			end
			return 1'b0;
		endfunction

		// Advance the prediction by one accepted character.
		function void note_input(input logic [7:0] ch, input logic last);
			decoded_t   r;
			logic [3:0] nib;
			bit         have;
			logic [7:0] val;
			have = 1'b0;
			val  = 8'd0;
			if (sticky == ST_OK) begin
				case (phase)
					PH_IDLE: begin
						if (out_count >= max_len) begin
							sticky = ST_TOO_LONG;
						end else if (ch == CH_PERCENT) begin
							phase = PH_PCT;
						end else if (ch == CH_PLUS) begin
							have = 1'b1;
							val  = CH_SPACE;
						end else begin
							have = 1'b1;
							val  = ch;
						end
					end
					PH_PCT: begin
						if (ch == CH_PERCENT) begin
							have  = 1'b1;
							val   = CH_PERCENT;
							phase = PH_IDLE;
						end else if (digit_value(ch, nib)) begin
							high_nib = nib;
							phase    = PH_HEX1;
						end else begin
							sticky = ST_MALFORMED;
							phase  = PH_IDLE;
						end
					end
					default: begin
						if (digit_value(ch, nib)) begin
							have = 1'b1;
							val  = {high_nib, nib};
						end else begin
							sticky = ST_MALFORMED;
						end
						phase = PH_IDLE;
					end
				endcase
				if (have)
					out_count = out_count + 16'd1;
			end
			if (last && sticky == ST_OK && phase != PH_IDLE)
				sticky = ST_MALFORMED;
			if (!have && !last)
				return;
			r.data    = have ? val : 8'd0;
			r.present = have;
			r.closing = last;
			r.status  = last ? sticky : ST_OK;
			owed_q.push_back(r);
			if (last)
				clear_string();
		endfunction

		function void check_result(input logic [7:0] data, input logic [2:0] user,
				input logic closing);
			decoded_t e;
			if (owed_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result data=%02h user=%03b last=%0b",
						$time, data, user, closing);
				return;
			end
			e = owed_q.pop_front();
			if (data !== e.data || user[0] !== e.present || user[2:1] !== e.status ||
					closing !== e.closing) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"%0t: result mismatch exp data=%02h valid=%0b status=%0d last=%0b",
						" got data=%02h valid=%0b status=%0d last=%0b"},
						$time, e.data, e.present, e.status, e.closing,
						data, user[0], user[2:1], closing);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] in_byte
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;   // [7:0] out_byte
	logic [2:0]  m_axis_tuser;   // [0] out_valid, [2:1] status
	logic        m_axis_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;

	decode_scoreboard sb;
	int tx_idle_pct;
	int rx_idle_pct;
	int items_sent;
	int results_seen;

	url_percent_decoder_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb_url_percent_decoder_top failed");
		$finish;
	end

	function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
		if (v < 4'd10)
			return CH_ZERO + 8'(v);
		return (upper ? CH_UP_A : CH_LOW_A) + 8'(v) - 8'd10;
	endfunction

	task automatic send_char(input logic [7:0] ch, input logic last);
		int gap;
		if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			gap = $urandom_range(16, 1);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= ch;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_input(ch, last);
		items_sent++;
	endtask

	task automatic send_string(input logic [7:0] chars[$]);
		for (int i = 0; i < chars.size(); i++)
			send_char(chars[i], i == chars.size() - 1);
	endtask

	task automatic send_text(input string s);
		logic [7:0] chars[$];
		for (int i = 0; i < s.len(); i++)
			chars.push_back(s[i]);
		send_string(chars);
	endtask

	// Mostly well-formed token sequences; the rest is escape-heavy noise.
	task automatic send_random_string();
		logic [7:0] chars[$];
		int         ntok;
		int         pick;
		logic [7:0] ch;
		if ($urandom_range(99) < 85) begin
			ntok = $urandom_range(20, 1);
			for (int t = 0; t < ntok; t++) begin
				pick = $urandom_range(99);
				if (pick < 50) begin
					ch = 8'($urandom_range(255));
					chars.push_back(ch == CH_PERCENT ? CH_PLUS : ch);
				end else if (pick < 60) begin
					chars.push_back(CH_PLUS);
				end else if (pick < 70) begin
					chars.push_back(CH_PERCENT);
					chars.push_back(CH_PERCENT);
				end else begin
					chars.push_back(CH_PERCENT);
					chars.push_back(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
					chars.push_back(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
				end
			end
		end else begin
			ntok = $urandom_range(8, 1);
			for (int t = 0; t < ntok; t++) begin
				pick = $urandom_range(99);
				if (pick < 40)
					chars.push_back(CH_PERCENT);
				else if (pick < 70)
					chars.push_back(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
				else
					chars.push_back(8'($urandom_range(255)));
			end
		end
		send_string(chars);
	endtask

	// Drain every owed result, then give the last non-result character time to retire.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (sb.owed_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_max_len(input logic [15:0] v);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.max_len = v;
	endtask

	// Result side: check every transfer, then pick the next tready.
	initial begin
		int  stall_left;
		bit  long_hold_done;
		stall_left     = 0;
		long_hold_done = 1'b0;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
				results_seen++;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (!long_hold_done && results_seen >= 250) begin
				// hold off long enough for the sender to back up against the block
				long_hold_done = 1'b1;
				stall_left     = 299;
				m_axis_tready <= 1'b0;
			end else if (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct) begin
				stall_left = $urandom_range(15, 0);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		logic [7:0]  extremes[$];
		logic [15:0] lim;
		int          phase_start;
		sb           = new();
		tx_idle_pct  = 0;
		rx_idle_pct  = 0;
		items_sent   = 0;
		results_seen = 0;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= 8'd0;
		s_axis_tlast  <= 1'b0;
		cfg_valid     <= 1'b0;
		cfg_data      <= 16'd0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed strings under the reset limit
		tx_idle_pct = 20;
		rx_idle_pct = 20;
		send_text("%4a+");
		send_text("%%");
		extremes = {8'h00, 8'hFF};
		send_string(extremes);
		send_text("%Fe");
		send_text("%zq%4");
		send_text("%4g");
		send_text("a%");
		send_text("%A");
		send_text("+");

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: lim = 16'd0;
				1: lim = 16'hFFFF;
				2: lim = 16'd3;
				3: lim = 16'd1;
				4: lim = 16'd16;
				5: lim = 16'($urandom_range(40, 0));
				default: lim = 16'd4095;
			endcase
			write_max_len(lim);
			if (p == NUM_PHASES - 1) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end else begin
				tx_idle_pct = ($urandom_range(2) == 0) ? 0 : 10 + 30 * $urandom_range(1);
				rx_idle_pct = ($urandom_range(2) == 0) ? 0 : 10 + 30 * $urandom_range(1);
			end
			if (p == 0)
				send_text("x");
			phase_start = items_sent;
			while (items_sent - phase_start < ITEMS_PER_PHASE)
				send_random_string();
		end

		wait_idle();
		repeat (4) @(posedge clk);
		if (sb.mismatches == 0 && sb.owed_q.size() == 0)
			$display("tb_url_percent_decoder_top passed");
		else
			$display("tb_url_percent_decoder_top failed");
		$finish;
	end

endmodule

// File: files.f
+incdir+sv
sv/upd_pkg.sv
sv/url_percent_decoder_top.sv
sv/upd_checker.sv
tb/tb_url_percent_decoder_top.sv
